// ===== rtl/ctr_pkg.sv =====
`default_nettype none
package ctr_pkg;

  localparam int KELVIN_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 15;

  localparam int KELVIN_W = 16;
  localparam int FIELD_W  = 16;

  // log2(100) in Q16
  localparam int LOG2_HUNDRED = 435412;

  localparam int GLN_A  = 17720;
  localparam int GLN_B  = 41408;
  localparam int BLN_A  = 24676;
  localparam int BLN_B  = 78398;
  localparam int RPOW_S = 84734;
  localparam int RPOW_E = 8730;
  localparam int GPOW_S = 74049;
  localparam int GPOW_E = 4949;

  localparam logic [15:0] RED_KNEE   = 16'd6600;
  localparam logic [15:0] BLUE_FLOOR = 16'd1900;
  localparam logic [15:0] POW_OFFSET = 16'd6000;
  localparam logic [15:0] BLN_OFFSET = 16'd1000;

  typedef logic signed [21:0] log_t;   // log2(x/100), Q16
  typedef logic signed [39:0] acc_t;   // fit value before rounding

  // log2(1+i/16), Q16
  localparam logic [17:0] LOG2_SEG [17] = '{
    18'd0, 18'd5732, 18'd11136, 18'd16248, 18'd21098, 18'd25711, 18'd30109,
    18'd34312, 18'd38336, 18'd42196, 18'd45904, 18'd49472, 18'd52911,
    18'd56229, 18'd59434, 18'd62534, 18'd65536
  };

  // 2^(i/16), Q16
  localparam logic [17:0] EXP2_SEG [17] = '{
    18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
    18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
  };

  typedef struct packed {
    logic le_knee;    // kelvin <= 6600
    logic ge_knee;    // kelvin >= 6600
    logic le_floor;   // kelvin <= 1900
    logic zero;
  } region_t;

  // clamp to [0,1] and round half up; value is acc / 2^(32+k)
  function automatic logic [15:0] ctr_round(acc_t acc, logic [1:0] k, int frac);
    logic [40:0] u;
    logic [40:0] half;
    logic [40:0] r;
    int s;
    r = '0;
    if (acc > 0) begin
      u = 41'(unsigned'(acc));
      if (u >= (41'd1 << (32 + int'(k)))) begin
        r = 41'd1 << frac;
      end else begin
        s = 32 + int'(k) - frac;
        half = 41'd1 << (s - 1);
        r = (u + half) >> s;
      end
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ctr_log2.sv =====
`default_nettype none
module ctr_log2 (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [15:0]    arg,
  output ctr_pkg::log_t       l
);
  import ctr_pkg::*;

  logic [3:0]  e;
  logic [15:0] frac;
  logic [3:0]  e_c;
  logic [31:0] sh_c;
  logic [17:0] lo, hi;
  logic [12:0] d;
  logic [24:0] prod;
  logic [21:0] lsum;

  always_comb begin
    e_c = '0;
    for (int i = 1; i < 16; i++) begin
      if (arg[i]) e_c = 4'(i);
    end
    sh_c = {arg, 16'd0} >> e_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e    <= e_c;
      frac <= sh_c[15:0];
    end
  end

  always_comb begin
    lo   = LOG2_SEG[frac[15:12]];
    hi   = LOG2_SEG[5'(frac[15:12]) + 5'd1];
    d    = 13'(hi - lo);
    prod = 25'(d) * 25'(frac[11:0]);
    lsum = {2'b00, e, 16'd0} + 22'(lo) + 22'(prod[24:12]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l <= log_t'(lsum) - log_t'(LOG2_HUNDRED);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ctr_lnfit.sv =====
`default_nettype none
module ctr_lnfit #(
  parameter int A = ctr_pkg::GLN_A,
  parameter int B = ctr_pkg::GLN_B
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ctr_pkg::log_t l,
  output ctr_pkg::acc_t      acc
);
  import ctr_pkg::*;

  acc_t acc3, acc4;

  always_ff @(posedge clk) begin
    if (en) begin
      acc3 <= acc_t'(A) * acc_t'(l) - (acc_t'(B) <<< 16);
      acc4 <= acc3;
      acc  <= acc4;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ctr_pow.sv =====
`default_nettype none
module ctr_pow #(
  parameter int SCALE = ctr_pkg::RPOW_S,
  parameter int EXPO  = ctr_pkg::RPOW_E
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ctr_pkg::log_t l,
  output ctr_pkg::acc_t      m,
  output logic [1:0]         k
);
  import ctr_pkg::*;

  logic [19:0] lc;
  logic [33:0] q;
  logic [17:0] p;
  logic [18:0] kw;
  logic [1:0]  k_c;
  logic [17:0] f_full;
  logic [15:0] f;
  logic [17:0] lo, hi;
  logic [12:0] d;
  logic [24:0] prod;
  logic [17:0] v;
  logic [1:0]  k4;

  always_comb begin
    lc = (l < 0) ? '0 : 20'(l);
    q  = 34'(EXPO) * 34'(lc) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) p <= q[33:16];
  end

  // k = ceil(p/65536), f = k*65536 - p, then 2^(f/65536) by table
  always_comb begin
    kw     = (19'(p) + 19'd65535) >> 16;
    k_c    = kw[1:0];
    f_full = {k_c, 16'd0} - p;
    f      = f_full[15:0];
    lo     = EXP2_SEG[f[15:12]];
    hi     = EXP2_SEG[5'(f[15:12]) + 5'd1];
    d      = 13'(hi - lo);
    prod   = 25'(d) * 25'(f[11:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v  <= lo + 18'(prod[24:12]);
      k4 <= k_c;
      m  <= acc_t'(v) * acc_t'(SCALE);
      k  <= k4;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/color_temperature_to_rgb_top.sv =====
`default_nettype none
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata[15:0] kelvin
// m_axis    out  tdata[15:0] red, [31:16] green, [47:32] blue
//
// Seven register stages, input to output; one beat per cycle sustained while the output is not stalled.
// The stages are argument select, log2 normalize/interp (2), fit multiply,
// exp2 interp, scale multiply and final rounding.
// Reset clears only the stage valid bits.
// A stall at the output freezes every stage together; s_tready follows it.
module color_temperature_to_rgb_top #(
  parameter int KELVIN_BITS = ctr_pkg::KELVIN_BITS_DEF,
  parameter int FRAC_BITS   = ctr_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // kelvin
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // red, green, blue
);
  import ctr_pkg::*;

  localparam logic [15:0] KMASK = (KELVIN_BITS >= 16) ? 16'hFFFF
                                   : 16'((32'd1 << KELVIN_BITS) - 32'd1);
  localparam logic [40:0] ONE_W = 41'd1 << FRAC_BITS;
  localparam logic [15:0] ONE_F = ONE_W[15:0];
  localparam int STAGES = 7;

  logic [STAGES-1:0] valid;
  logic              en;
  logic [15:0]       n;
  logic [15:0]       g_arg, b_arg;
  region_t           reg_s [STAGES-1];
  region_t           reg_c;
  log_t              l_g, l_b;
  acc_t              acc_g, acc_b, m_r, m_g;
  logic [1:0]        k_r, k_g;
  logic [15:0]       red, green, blue;

  assign en       = !valid[STAGES-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = valid[STAGES-1];
  assign n        = s_tdata & KMASK;

  always_comb begin
    reg_c.le_knee  = (n <= RED_KNEE);
    reg_c.ge_knee  = (n >= RED_KNEE);
    reg_c.le_floor = (n <= BLUE_FLOOR);
    reg_c.zero     = (n == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[STAGES-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_arg    <= (n <= RED_KNEE) ? n : n - POW_OFFSET;
      b_arg    <= n - BLN_OFFSET;
      reg_s[0] <= reg_c;
      for (int i = 1; i < STAGES - 1; i++) reg_s[i] <= reg_s[i-1];
    end
  end

  ctr_log2 u_log_g (.clk(clk), .en(en), .arg(g_arg), .l(l_g));
  ctr_log2 u_log_b (.clk(clk), .en(en), .arg(b_arg), .l(l_b));

  ctr_lnfit #(.A(GLN_A), .B(GLN_B)) u_ln_g (.clk(clk), .en(en), .l(l_g), .acc(acc_g));
  ctr_lnfit #(.A(BLN_A), .B(BLN_B)) u_ln_b (.clk(clk), .en(en), .l(l_b), .acc(acc_b));

  ctr_pow #(.SCALE(RPOW_S), .EXPO(RPOW_E)) u_pow_r (
    .clk(clk), .en(en), .l(l_g), .m(m_r), .k(k_r)
  );
  ctr_pow #(.SCALE(GPOW_S), .EXPO(GPOW_E)) u_pow_g (
    .clk(clk), .en(en), .l(l_g), .m(m_g), .k(k_g)
  );

  always_comb begin
    red   = reg_s[STAGES-2].le_knee ? ONE_F : ctr_round(m_r, k_r, FRAC_BITS);
    if (reg_s[STAGES-2].zero) begin
      green = '0;
    end else if (reg_s[STAGES-2].le_knee) begin
      green = ctr_round(acc_g, 2'd0, FRAC_BITS);
    end else begin
      green = ctr_round(m_g, k_g, FRAC_BITS);
    end
    if (reg_s[STAGES-2].ge_knee) begin
      blue = ONE_F;
    end else if (reg_s[STAGES-2].le_floor) begin
      blue = '0;
    end else begin
      blue = ctr_round(acc_b, 2'd0, FRAC_BITS);
    end
  end

  region_t reg_out;

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {blue, green, red};
      reg_out <= reg_s[STAGES-2];
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready) else $error("input taken during stall");

  a_red_one_low_temp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && reg_out.le_knee) |-> (m_tdata[15:0] == ONE_F))
    else $error("red not full below knee");

  a_blue_zero_cold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && reg_out.le_floor) |-> (m_tdata[47:32] == 16'd0))
    else $error("blue not zero below floor");

  a_green_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && FRAC_BITS <= 15) |-> (m_tdata[31:16] <= ONE_F))
    else $error("green above one");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ctr_pkg::*;

  localparam int LATENCY = 7;
  localparam logic [15:0] ONE = 16'd32768;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  typedef struct {
    logic [15:0] kelvin;
    logic        known;
    rgb_t        rgb;
  } row_t;

  rgb_t pending_rgb[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles = 0;

  color_temperature_to_rgb_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic longint log2_q16(longint unsigned n);
    int e;
    longint unsigned frac, idx, rem, lo, hi;
    if (n == 0) return 0;
    e = 0;
    while (e < 40 && (n >> (e + 1)) != 0) e++;
    frac = ((n << 16) >> e) - 65536;
    idx = (frac >> 12) & 15;
    rem = frac & 4095;
    lo = LOG2_SEG[idx];
    hi = LOG2_SEG[idx + 1];
    return longint'(e) * 65536 + longint'(lo + (((hi - lo) * rem) >> 12));
  endfunction

  function automatic logic [15:0] clamp_round(longint acc, int extra);
    longint unsigned u, r;
    int s;
    if (acc <= 0 || extra > 24) return '0;
    u = longint'(acc);
    if (u >= (64'd1 << (32 + extra))) return ONE;
    s = 32 + extra - FRAC_BITS_DEF;
    r = (u + (64'd1 << (s - 1))) >> s;
    return r[15:0];
  endfunction

  function automatic logic [15:0] pow_weight(longint unsigned n, longint scale, longint expo);
    longint l;
    longint unsigned q, p, k, f, idx, rem, lo, hi, m;
    l = log2_q16(n) - LOG2_HUNDRED;
    if (l < 0) l = 0;
    q = expo * l;
    p = (q + 32768) >> 16;
    k = (p + 65535) >> 16;
    if (k > 24) return '0;
    f = (k << 16) - p;
    idx = (f >> 12) & 15;
    rem = f & 4095;
    lo = EXP2_SEG[idx];
    hi = EXP2_SEG[idx + 1];
    m = (lo + (((hi - lo) * rem) >> 12)) * scale;
    return clamp_round(longint'(m), int'(k));
  endfunction

  function automatic logic [15:0] log_weight(longint unsigned n, longint a, longint b);
    return clamp_round(a * (log2_q16(n) - LOG2_HUNDRED) - b * 65536, 0);
  endfunction

  function automatic rgb_t kelvin_to_rgb(logic [15:0] kelvin);
    rgb_t c;
    longint unsigned n;
    n = kelvin;
    if (n <= RED_KNEE) begin
      c.red = ONE;
      c.green = (n == 0) ? 16'd0 : log_weight(n, GLN_A, GLN_B);
    end else begin
      c.red = pow_weight(n - POW_OFFSET, RPOW_S, RPOW_E);
      c.green = pow_weight(n - POW_OFFSET, GPOW_S, GPOW_E);
    end
    if (n >= RED_KNEE) c.blue = ONE;
    else if (n <= BLUE_FLOOR) c.blue = '0;
    else c.blue = log_weight(n - BLN_OFFSET, BLN_A, BLN_B);
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // one beat per call; waits for the handshake, tvalid stays up for the next call
  task automatic send_kelvin(logic [15:0] kelvin, rgb_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= kelvin;
    pending_rgb.push_back(want);
    do @(posedge clk); while (!s_tready);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_rgb.size() == 0) begin
          $display("%0t unexpected beat %h", $realtime, m_tdata);
          errors++;
        end else begin
          rgb_t want, got;
          want = pending_rgb.pop_front();
          got = m_tdata;
          if (got.red !== want.red) report_mismatch("red", got.red, want.red);
          if (got.green !== want.green) report_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic random_phase(int count);
    logic [15:0] k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: k = 16'($urandom);
        1: k = 16'($urandom_range(2000));
        2: k = 16'($urandom_range(6700, 6500));
        3: k = 16'($urandom_range(6600, 1900));
        default: k = 16'($urandom_range(40000));
      endcase
      send_kelvin(k, kelvin_to_rgb(k));
    end
  endtask

  row_t rows[$];
  int waited;

  initial begin
    rows = '{
      '{16'd0,     1'b1, '{16'd0, 16'd0, ONE}},
      '{16'd1,     1'b0, '0},
      '{16'd1900,  1'b0, '0},
      '{16'd1901,  1'b0, '0},
      '{16'd6599,  1'b0, '0},
      '{16'd6600,  1'b0, '0},
      '{16'd6601,  1'b0, '0},
      '{16'd6000,  1'b0, '0},
      '{16'd1000,  1'b0, '0},
      '{16'd100,   1'b0, '0},
      '{16'd4000,  1'b0, '0},
      '{16'd12000, 1'b0, '0},
      '{16'd40000, 1'b0, '0},
      '{16'd65535, 1'b0, '0},
      '{16'hAAAA,  1'b0, '0},
      '{16'h5555,  1'b0, '0},
      '{16'h8000,  1'b0, '0}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 22; recv_idle_pct = 63;
    foreach (rows[i])
      send_kelvin(rows[i].kelvin,
                  rows[i].known ? rows[i].rgb : kelvin_to_rgb(rows[i].kelvin));
    random_phase(450);

    // long output stall while input keeps coming: pipeline fills, s_tready drops
    send_idle_pct = 0;
    hold_cycles <= 60;
    random_phase(30);
    s_tvalid <= 1'b0;

    // drain fully before switching
    while (pending_rgb.size() != 0) @(posedge clk);
    send_idle_pct = 63; recv_idle_pct = 22;
    random_phase(450);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(450);
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending_rgb.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY * 4) @(posedge clk);
    if (errors == 0 && pending_rgb.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
